/* hw/rtl/velocity_rotate_and_integrate_top_assert.svh */
// assertion macros for the velocity rotate and integrate block
// used by the port checker; expects clk and arst_n in scope
`ifndef VELOCITY_ROTATE_AND_INTEGRATE_TOP_ASSERT_SVH
`define VELOCITY_ROTATE_AND_INTEGRATE_TOP_ASSERT_SVH

// condition holds in the same cycle
`define VRI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the following cycle
`define VRI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/vri_pkg.sv */
// shared types and fixed-point constants of the velocity rotate and integrate block
// no dependencies
`default_nettype none

package vri_pkg;

	localparam int QUAT_W        = 16;  // quaternion part, Q1.14
	localparam int DT_W          = 16;  // time step, unsigned Q0.16
	localparam int COEF_W        = 26;  // rotation coefficient, Q20
	localparam int QPROD_W       = 34;  // kept bits of a quaternion product sum
	localparam int COEF_T_W      = 36;  // coefficient before rounding to Q20
	localparam int COEF_SHIFT    = 8;   // Q28 -> Q20
	localparam int VEL_RND_SHIFT = 20;  // Q28 -> Q8
	localparam int POS_RND_SHIFT = 9;   // Q24 -> Q16 with the halving

	// 1.0 in Q28 plus the half-lsb for the shift to Q20
	localparam logic signed [COEF_T_W-1:0] ONE_RND  = 36'sd268435584;
	localparam logic signed [COEF_T_W-1:0] HALF_RND = 36'sd128;

	typedef struct packed {
		logic load;  // capture operands, clear accumulator
		logic step;  // consume one multiplier bit
		logic neg;   // multiplier sign bit: subtract
	} smac_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/velocity_rotate_and_integrate_top.sv */
// velocity rotate and integrate: quaternion rotation of body velocity and trapezoidal
// position update; depends on vri_pkg and vri_smac
//
//  channel | dir | handshake          | fields
//  in      | in  | in_valid/in_ready  | body_vel_x/y, quat_w/x/y/z, time_step
//  out     | out | out_valid/out_ready| nav_vel_x/y, nav_pos_x/y
//
// WB = max(16, VEL_WIDTH+1) is the multiplier width of each pass; two bit-serial
// multiply-accumulate units take one multiplier bit a cycle over four passes: quaternion
// squares, quaternion cross terms, rotation, integration
// in_ready is high only between items; a new item is taken while a result waits
// the last pass holds until the waiting result is taken
// arst_n clears stored velocity and position to zero
`default_nettype none

module velocity_rotate_and_integrate_top #(
	parameter int VEL_WIDTH = 16,
	parameter int POS_WIDTH = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic signed [VEL_WIDTH-1:0]        body_vel_x,
	input  wire logic signed [VEL_WIDTH-1:0]        body_vel_y,
	input  wire logic signed [vri_pkg::QUAT_W-1:0]  quat_w,
	input  wire logic signed [vri_pkg::QUAT_W-1:0]  quat_x,
	input  wire logic signed [vri_pkg::QUAT_W-1:0]  quat_y,
	input  wire logic signed [vri_pkg::QUAT_W-1:0]  quat_z,
	input  wire logic        [vri_pkg::DT_W-1:0]    time_step,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [VEL_WIDTH-1:0]             nav_vel_x,
	output logic signed [VEL_WIDTH-1:0]             nav_vel_y,
	output logic signed [POS_WIDTH-1:0]             nav_pos_x,
	output logic signed [POS_WIDTH-1:0]             nav_pos_y
);

	import vri_pkg::*;

	localparam int WB    = (VEL_WIDTH + 1 > QUAT_W) ? VEL_WIDTH + 1 : QUAT_W;
	localparam int WA    = COEF_W;
	localparam int WP    = WA + 2 + WB;
	localparam int WQ    = WP - VEL_RND_SHIFT;
	localparam int WI    = WP - POS_RND_SHIFT;
	localparam int WS    = ((POS_WIDTH > WI) ? POS_WIDTH : WI) + 1;
	localparam int CNT_W = $clog2(WB);

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WB - 1);
	localparam logic [WP-1:0]    VEL_HALF = WP'(1) << (VEL_RND_SHIFT - 1);
	localparam logic [WP-1:0]    POS_HALF = WP'(1) << (POS_RND_SHIFT - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MUL  = 2'd1;
	localparam logic [1:0] S_NEXT = 2'd2;

	localparam logic [1:0] PH_QSQ = 2'd0;
	localparam logic [1:0] PH_QX  = 2'd1;
	localparam logic [1:0] PH_VEL = 2'd2;
	localparam logic [1:0] PH_DT  = 2'd3;

	function automatic logic signed [VEL_WIDTH-1:0] sat_vel(input logic [WQ-1:0] v);
		logic fits;
		fits = (&v[WQ-1:VEL_WIDTH-1]) | ~(|v[WQ-1:VEL_WIDTH-1]);
		if (fits)
			return v[VEL_WIDTH-1:0];
		else if (v[WQ-1])
			return {1'b1, {(VEL_WIDTH-1){1'b0}}};
		else
			return {1'b0, {(VEL_WIDTH-1){1'b1}}};
	endfunction

	function automatic logic signed [POS_WIDTH-1:0] sat_pos(input logic [WS-1:0] v);
		logic fits;
		fits = (&v[WS-1:POS_WIDTH-1]) | ~(|v[WS-1:POS_WIDTH-1]);
		if (fits)
			return v[POS_WIDTH-1:0];
		else if (v[WS-1])
			return {1'b1, {(POS_WIDTH-1){1'b0}}};
		else
			return {1'b0, {(POS_WIDTH-1){1'b1}}};
	endfunction

	logic [1:0]       state_q, phase_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;

	logic signed [VEL_WIDTH-1:0] vx_q, vy_q, nx_q, ny_q, lvx_q, lvy_q;
	logic signed [QUAT_W-1:0]    qw_q, qx_q, qy_q, qz_q;
	logic        [DT_W-1:0]      dt_q;
	logic signed [WA-1:0]        coef_a_q, coef_d_q;
	logic signed [POS_WIDTH-1:0] pos_x_q, pos_y_q;

	logic accept, finish;
	smac_ctrl_t ctrl;

	logic signed [WA-1:0] opa_a1, opa_a2, opb_a1, opb_a2;
	logic signed [WB-1:0] opa_b1, opa_b2, opb_b1, opb_b2;
	logic signed [WP-1:0] prod_a, prod_b;

	logic signed [QPROD_W-1:0]  qa, qb;
	logic signed [COEF_T_W-1:0] tsq_a, tsq_b, tcr_a, tcr_b;
	logic [WP-1:0]              rv_a, rv_b, rp_a, rp_b;
	logic signed [VEL_WIDTH-1:0] nx_c, ny_c;
	logic signed [VEL_WIDTH:0]   sx_c, sy_c;
	logic signed [WI-1:0]        inc_x, inc_y;
	logic signed [WS-1:0]        px_sum, py_sum;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign finish   = (state_q == S_NEXT) && (phase_q == PH_DT) &&
	                  (!out_valid_q || out_ready);

	always_comb begin
		ctrl.load = accept || ((state_q == S_NEXT) && (phase_q != PH_DT));
		ctrl.step = (state_q == S_MUL);
		ctrl.neg  = (state_q == S_MUL) && (cnt_q == CNT_LAST);
	end

	// pass results: coefficients, rotated velocity, position increment
	always_comb begin
		qa    = prod_a[QPROD_W-1:0];
		qb    = prod_b[QPROD_W-1:0];
		tsq_a = ONE_RND - (COEF_T_W'(qa) <<< 1);
		tsq_b = ONE_RND - (COEF_T_W'(qb) <<< 1);
		tcr_a = (COEF_T_W'(qa) <<< 1) + HALF_RND;
		tcr_b = (COEF_T_W'(qb) <<< 1) + HALF_RND;
		rv_a  = prod_a + VEL_HALF;
		rv_b  = prod_b + VEL_HALF;
		nx_c  = sat_vel(rv_a[WP-1:VEL_RND_SHIFT]);
		ny_c  = sat_vel(rv_b[WP-1:VEL_RND_SHIFT]);
		sx_c  = (VEL_WIDTH+1)'(nx_c) + (VEL_WIDTH+1)'(lvx_q);
		sy_c  = (VEL_WIDTH+1)'(ny_c) + (VEL_WIDTH+1)'(lvy_q);
		rp_a  = prod_a + POS_HALF;
		rp_b  = prod_b + POS_HALF;
		inc_x = rp_a[WP-1:POS_RND_SHIFT];
		inc_y = rp_b[WP-1:POS_RND_SHIFT];
		px_sum = WS'(pos_x_q) + WS'(inc_x);
		py_sum = WS'(pos_y_q) + WS'(inc_y);
	end

	// operands for the next pass
	always_comb begin
		opa_a1 = '0;
		opa_a2 = '0;
		opa_b1 = '0;
		opa_b2 = '0;
		opb_a1 = '0;
		opb_a2 = '0;
		opb_b1 = '0;
		opb_b2 = '0;
		unique case (state_q)
			S_IDLE: begin
				opa_a1 = WA'(quat_y);
				opa_b1 = WB'(quat_y);
				opa_a2 = WA'(quat_z);
				opa_b2 = WB'(quat_z);
				opb_a1 = WA'(quat_x);
				opb_b1 = WB'(quat_x);
				opb_a2 = WA'(quat_z);
				opb_b2 = WB'(quat_z);
			end
			S_NEXT: begin
				unique case (phase_q)
					PH_QSQ: begin
						opa_a1 = WA'(qx_q);
						opa_b1 = WB'(qy_q);
						opa_a2 = WA'(qw_q);
						opa_b2 = WB'(qz_q);
						opb_a1 = WA'(qx_q);
						opb_b1 = WB'(qy_q);
						opb_a2 = -WA'(qw_q);
						opb_b2 = WB'(qz_q);
					end
					PH_QX: begin
						opa_a1 = coef_a_q;
						opa_b1 = WB'(vx_q);
						opa_a2 = tcr_a[COEF_SHIFT+COEF_W-1:COEF_SHIFT];
						opa_b2 = WB'(vy_q);
						opb_a1 = tcr_b[COEF_SHIFT+COEF_W-1:COEF_SHIFT];
						opb_b1 = WB'(vx_q);
						opb_a2 = coef_d_q;
						opb_b2 = WB'(vy_q);
					end
					PH_VEL: begin
						opa_a1 = WA'({1'b0, dt_q});
						opa_b1 = WB'(sx_c);
						opb_a1 = WA'({1'b0, dt_q});
						opb_b1 = WB'(sy_c);
					end
					PH_DT: begin
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	vri_smac #(.WA(WA), .WB(WB)) u_smac_a (
		.clk  (clk),
		.ctrl (ctrl),
		.a1   (opa_a1),
		.a2   (opa_a2),
		.b1   (opa_b1),
		.b2   (opa_b2),
		.prod (prod_a)
	);

	vri_smac #(.WA(WA), .WB(WB)) u_smac_b (
		.clk  (clk),
		.ctrl (ctrl),
		.a1   (opb_a1),
		.a2   (opb_a2),
		.b1   (opb_b1),
		.b2   (opb_b2),
		.prod (prod_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_QSQ;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			lvx_q       <= '0;
			lvy_q       <= '0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MUL;
						phase_q <= PH_QSQ;
						cnt_q   <= '0;
					end
				end
				S_MUL: begin
					if (cnt_q == CNT_LAST) begin
						cnt_q   <= '0;
						state_q <= S_NEXT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_NEXT: begin
					unique case (phase_q)
						PH_QSQ: begin
							phase_q <= PH_QX;
							state_q <= S_MUL;
						end
						PH_QX: begin
							phase_q <= PH_VEL;
							state_q <= S_MUL;
						end
						PH_VEL: begin
							phase_q <= PH_DT;
							state_q <= S_MUL;
						end
						PH_DT: begin
							if (finish) begin
								lvx_q       <= nx_q;
								lvy_q       <= ny_q;
								pos_x_q     <= sat_pos(px_sum);
								pos_y_q     <= sat_pos(py_sum);
								out_valid_q <= 1'b1;
								state_q     <= S_IDLE;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vx_q <= body_vel_x;
			vy_q <= body_vel_y;
			qw_q <= quat_w;
			qx_q <= quat_x;
			qy_q <= quat_y;
			qz_q <= quat_z;
			dt_q <= time_step;
		end
		if ((state_q == S_NEXT) && (phase_q == PH_QSQ)) begin
			coef_a_q <= tsq_a[COEF_SHIFT+COEF_W-1:COEF_SHIFT];
			coef_d_q <= tsq_b[COEF_SHIFT+COEF_W-1:COEF_SHIFT];
		end
		if ((state_q == S_NEXT) && (phase_q == PH_VEL)) begin
			nx_q <= nx_c;
			ny_q <= ny_c;
		end
	end

	// stored state doubles as the result, it only moves when a result is presented
	assign out_valid = out_valid_q;
	assign nav_vel_x = lvx_q;
	assign nav_vel_y = lvy_q;
	assign nav_pos_x = pos_x_q;
	assign nav_pos_y = pos_y_q;

endmodule

`default_nettype wire

/* hw/rtl/vri_smac.sv */
// bit-serial multiply-accumulate: a1*b1 + a2*b2, one multiplier bit per cycle while ctrl.step is set, lsb first
// depends on vri_pkg (control struct)
`default_nettype none

module vri_smac #(
	parameter int WA = 26,
	parameter int WB = 17
) (
	input  wire logic                      clk,
	input  wire vri_pkg::smac_ctrl_t       ctrl,
	input  wire logic signed [WA-1:0]      a1,
	input  wire logic signed [WA-1:0]      a2,
	input  wire logic signed [WB-1:0]      b1,
	input  wire logic signed [WB-1:0]      b2,
	output logic signed [WA+WB+1:0]        prod
);

	logic signed [WA-1:0] a1_q, a2_q;
	logic        [WB-1:0] b1_q, b2_q;
	logic signed [WA+1:0] acc_q;
	logic        [WB-1:0] lo_q;

	logic signed [WA+1:0] pp, pp_sel;
	logic signed [WA+2:0] sum;

	always_comb begin
		pp = (b1_q[0] ? (WA+2)'(a1_q) : '0) + (b2_q[0] ? (WA+2)'(a2_q) : '0);
		pp_sel = ctrl.neg ? -pp : pp;
		sum = (WA+3)'(acc_q) + (WA+3)'(pp_sel);
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			a1_q  <= a1;
			a2_q  <= a2;
			b1_q  <= b1;
			b2_q  <= b2;
			acc_q <= '0;
			lo_q  <= '0;
		end else if (ctrl.step) begin
			acc_q <= sum[WA+2:1];
			lo_q  <= {sum[0], lo_q[WB-1:1]};
			b1_q  <= {b1_q[WB-1], b1_q[WB-1:1]};
			b2_q  <= {b2_q[WB-1], b2_q[WB-1:1]};
		end
	end

	assign prod = {acc_q, lo_q};

endmodule

`default_nettype wire

/* hw/rtl/vri_checker.sv */
// port checker for velocity_rotate_and_integrate_top, attached by bind
// depends on vri_pkg and velocity_rotate_and_integrate_top_assert.svh
`default_nettype none
`include "velocity_rotate_and_integrate_top_assert.svh"

module vri_checker #(
	parameter int VEL_WIDTH = 16,
	parameter int POS_WIDTH = 32
) (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               in_valid,
	input wire logic                               in_ready,
	input wire logic signed [VEL_WIDTH-1:0]        body_vel_x,
	input wire logic signed [VEL_WIDTH-1:0]        body_vel_y,
	input wire logic signed [vri_pkg::QUAT_W-1:0]  quat_w,
	input wire logic signed [vri_pkg::QUAT_W-1:0]  quat_x,
	input wire logic signed [vri_pkg::QUAT_W-1:0]  quat_y,
	input wire logic signed [vri_pkg::QUAT_W-1:0]  quat_z,
	input wire logic        [vri_pkg::DT_W-1:0]    time_step,
	input wire logic                               out_valid,
	input wire logic                               out_ready,
	input wire logic signed [VEL_WIDTH-1:0]        nav_vel_x,
	input wire logic signed [VEL_WIDTH-1:0]        nav_vel_y,
	input wire logic signed [POS_WIDTH-1:0]        nav_pos_x,
	input wire logic signed [POS_WIDTH-1:0]        nav_pos_y
);

	// a waiting input transaction keeps its payload
	`VRI_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(body_vel_x) && $stable(body_vel_y) && $stable(quat_w) && $stable(quat_x) && $stable(quat_y) && $stable(quat_z) && $stable(time_step), "input changed while waiting")

	// a stalled result keeps its payload
	`VRI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(nav_vel_x) && $stable(nav_vel_y) && $stable(nav_pos_x) && $stable(nav_pos_y), "result changed while stalled")

	// an accepted transaction takes in_ready low
	`VRI_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after accept")

	// stored velocity and position move only together with a presented result
	`VRI_ASSERT_NOW(a_state_with_result, !$stable(nav_pos_x) || !$stable(nav_pos_y) || !$stable(nav_vel_x) || !$stable(nav_vel_y), out_valid, "state moved without result")

	// finishing an item frees the input side
	`VRI_ASSERT_NOW(a_idle_on_result, $rose(out_valid), in_ready, "not ready when result appears")

endmodule

bind velocity_rotate_and_integrate_top vri_checker #(
	.VEL_WIDTH (VEL_WIDTH),
	.POS_WIDTH (POS_WIDTH)
) u_vri_checker (.*);

`default_nettype wire
